### rtl/rrcs_pkg.sv
package rrcs_pkg;

    localparam int STORE_DEPTH = 32;
    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int COORD_W = 16;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_INTERSECT = 2'd1;
    localparam logic [1:0] OP_SUBTRACT = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    localparam logic [1:0] STATUS_EMPTY = 2'd0;
    localparam logic [1:0] STATUS_NONEMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] fl;
        logic [COORD_W-1:0] fc;
        logic [COORD_W-1:0] ll;
        logic [COORD_W-1:0] lc;
    } rect_t;

    localparam int RECT_W = $bits(rect_t);

endpackage

### rtl/rect_region_clip_subtract.sv
// Rectangle region store. Each input transaction is taken only while the block is idle.
// An add writes a non-inverted operand into the lowest free slot; the other ops walk the
// slots in order through the store's read port, and a subtract tries each candidate piece
// in turn for every overlapped rectangle. Each op gives one result transaction; a read
// gives one per stored rectangle in slot order, each waiting for the output register to
// be free.
module rect_region_clip_subtract (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [15:0] first_line,
    input  logic [15:0] first_column,
    input  logic [15:0] last_line,
    input  logic [15:0] last_column,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        rect_valid,
    output logic [15:0] out_first_line,
    output logic [15:0] out_first_column,
    output logic [15:0] out_last_line,
    output logic [15:0] out_last_column,
    output logic        last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADD = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_WORK = 3'd4;
    localparam logic [2:0] ST_PIECE = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] op_reg, op_next;
    rrcs_pkg::rect_t opnd_reg, opnd_next;
    rrcs_pkg::rect_t r_reg, r_next;
    logic [rrcs_pkg::STORE_DEPTH-1:0] valid_reg, valid_next;
    logic [rrcs_pkg::STORE_DEPTH-1:0] snap_reg, snap_next;
    logic [rrcs_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [1:0] step_reg, step_next;
    logic full_reg, full_next;

    logic out_valid_reg, out_valid_next;
    logic [1:0] status_reg, status_next;
    logic rect_valid_reg, rect_valid_next;
    rrcs_pkg::rect_t out_rect_reg, out_rect_next;
    logic last_reg, last_next;

    logic we;
    logic [rrcs_pkg::IDX_W-1:0] waddr;
    rrcs_pkg::rect_t wdata;
    rrcs_pkg::rect_t rdata;
    logic [rrcs_pkg::RECT_W-1:0] rdata_bits;

    logic [rrcs_pkg::IDX_W-1:0] cur;
    logic free_found;
    logic [rrcs_pkg::IDX_W-1:0] free_idx;
    logic higher_valid;
    logic inverted;
    logic overlap;
    logic out_free;
    logic piece_cond;
    rrcs_pkg::rect_t piece;
    rrcs_pkg::rect_t trimmed;

    assign cur = idx_reg[rrcs_pkg::IDX_W-1:0];
    assign rdata = rdata_bits;

    rrcs_ram #(
        .WIDTH(rrcs_pkg::RECT_W),
        .DEPTH(rrcs_pkg::STORE_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(cur),
        .rdata(rdata_bits)
    );

    always_comb
    begin
        free_found = 1'b0;
        free_idx = '0;
        for (int j = rrcs_pkg::STORE_DEPTH - 1; j >= 0; j--)
        begin
            if (!valid_reg[j])
            begin
                free_found = 1'b1;
                free_idx = rrcs_pkg::IDX_W'(j);
            end
        end
    end

    always_comb
    begin
        higher_valid = 1'b0;
        for (int j = 0; j < rrcs_pkg::STORE_DEPTH; j++)
        begin
            if (rrcs_pkg::CNT_W'(j) > idx_reg && snap_reg[j])
            begin
                higher_valid = 1'b1;
            end
        end
    end

    assign inverted = (opnd_reg.ll < opnd_reg.fl) || (opnd_reg.lc < opnd_reg.fc);
    assign overlap = !(r_reg.fl > opnd_reg.ll || r_reg.ll < opnd_reg.fl ||
                       r_reg.fc > opnd_reg.lc || r_reg.lc < opnd_reg.fc);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        trimmed = r_reg;
        if (r_reg.fl < opnd_reg.fl) trimmed.fl = opnd_reg.fl;
        if (r_reg.ll > opnd_reg.ll) trimmed.ll = opnd_reg.ll;
        if (r_reg.fc < opnd_reg.fc) trimmed.fc = opnd_reg.fc;
        if (r_reg.lc > opnd_reg.lc) trimmed.lc = opnd_reg.lc;
    end

    always_comb
    begin
        piece = r_reg;
        piece_cond = 1'b0;
        case (step_reg)
            2'd0:
            begin
                piece_cond = r_reg.fl < opnd_reg.fl;
                piece.ll = opnd_reg.fl - 16'd1;
            end
            2'd1:
            begin
                piece_cond = r_reg.ll > opnd_reg.ll;
                piece.fl = opnd_reg.ll + 16'd1;
            end
            2'd2:
            begin
                piece_cond = r_reg.fc < opnd_reg.fc;
                piece.lc = opnd_reg.fc - 16'd1;
            end
            default:
            begin
                piece_cond = r_reg.lc > opnd_reg.lc;
                piece.fc = opnd_reg.lc + 16'd1;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        opnd_next = opnd_reg;
        r_next = r_reg;
        valid_next = valid_reg;
        snap_next = snap_reg;
        idx_next = idx_reg;
        step_next = step_reg;
        full_next = full_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next = status_reg;
        rect_valid_next = rect_valid_reg;
        out_rect_next = out_rect_reg;
        last_next = last_reg;
        we = 1'b0;
        waddr = free_idx;
        wdata = opnd_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = op;
                    opnd_next = '{fl: first_line, fc: first_column,
                                  ll: last_line, lc: last_column};
                    snap_next = valid_reg;
                    idx_next = '0;
                    full_next = 1'b0;
                    state_next = (op == rrcs_pkg::OP_ADD) ? ST_ADD : ST_SCAN;
                end
            end
            ST_ADD:
            begin
                if (!inverted)
                begin
                    if (free_found)
                    begin
                        we = 1'b1;
                        valid_next[free_idx] = 1'b1;
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                end
                state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                if (idx_reg == rrcs_pkg::CNT_W'(rrcs_pkg::STORE_DEPTH) ||
                    (op_reg == rrcs_pkg::OP_SUBTRACT && inverted))
                begin
                    state_next = ST_FINISH;
                end
                else if (snap_reg[cur])
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    idx_next = idx_reg + rrcs_pkg::CNT_W'(1);
                end
            end
            ST_LOAD:
            begin
                r_next = rdata;
                step_next = '0;
                state_next = ST_WORK;
            end
            ST_WORK:
            begin
                case (op_reg)
                    rrcs_pkg::OP_READ:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            status_next = rrcs_pkg::STATUS_NONEMPTY;
                            rect_valid_next = 1'b1;
                            out_rect_next = r_reg;
                            last_next = !higher_valid;
                            idx_next = idx_reg + rrcs_pkg::CNT_W'(1);
                            state_next = ST_SCAN;
                        end
                    end
                    rrcs_pkg::OP_INTERSECT:
                    begin
                        if (inverted || !overlap)
                        begin
                            valid_next[cur] = 1'b0;
                        end
                        else
                        begin
                            we = 1'b1;
                            waddr = cur;
                            wdata = trimmed;
                        end
                        idx_next = idx_reg + rrcs_pkg::CNT_W'(1);
                        state_next = ST_SCAN;
                    end
                    default:
                    begin
                        if (overlap)
                        begin
                            state_next = ST_PIECE;
                        end
                        else
                        begin
                            idx_next = idx_reg + rrcs_pkg::CNT_W'(1);
                            state_next = ST_SCAN;
                        end
                    end
                endcase
            end
            ST_PIECE:
            begin
                if (piece_cond && !free_found)
                begin
                    we = 1'b1;
                    waddr = cur;
                    wdata = r_reg;
                    full_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    if (piece_cond)
                    begin
                        we = 1'b1;
                        wdata = piece;
                        valid_next[free_idx] = 1'b1;
                        if (step_reg == 2'd0) r_next.fl = opnd_reg.fl;
                        if (step_reg == 2'd1) r_next.ll = opnd_reg.ll;
                    end
                    step_next = step_reg + 2'd1;
                    if (step_reg == 2'd3)
                    begin
                        valid_next[cur] = 1'b0;
                        idx_next = idx_reg + rrcs_pkg::CNT_W'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_FINISH:
            begin
                if (op_reg == rrcs_pkg::OP_READ && snap_reg != '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    rect_valid_next = 1'b0;
                    out_rect_next = '0;
                    last_next = 1'b1;
                    if (full_reg)
                        status_next = rrcs_pkg::STATUS_FULL;
                    else if (valid_reg == '0)
                        status_next = rrcs_pkg::STATUS_EMPTY;
                    else
                        status_next = rrcs_pkg::STATUS_NONEMPTY;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
            full_reg <= 1'b0;
            idx_reg <= '0;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            out_valid_reg <= out_valid_next;
            full_reg <= full_next;
            idx_reg <= idx_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        opnd_reg <= opnd_next;
        r_reg <= r_next;
        snap_reg <= snap_next;
        status_reg <= status_next;
        rect_valid_reg <= rect_valid_next;
        out_rect_reg <= out_rect_next;
        last_reg <= last_next;
    end

    assign in_stall = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign rect_valid = rect_valid_reg;
    assign out_first_line = out_rect_reg.fl;
    assign out_first_column = out_rect_reg.fc;
    assign out_last_line = out_rect_reg.ll;
    assign out_last_column = out_rect_reg.lc;
    assign last = last_reg;

endmodule

### rtl/rrcs_ram.sv
module rrcs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/rrcs_checker.sv
module rrcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic        rect_valid,
    input logic [15:0] out_first_line,
    input logic        last
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(last) &&
            $stable(out_first_line))
        else $error("Stalled result transaction changed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Block did not go busy after an input transaction.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rect_valid |-> status == rrcs_pkg::STATUS_NONEMPTY)
        else $error("Rectangle result with wrong status.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rect_valid |-> last && out_first_line == 16'd0)
        else $error("Status result is not a final zero transaction.");

endmodule

bind rect_region_clip_subtract rrcs_checker u_rrcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .rect_valid    (rect_valid),
    .out_first_line(out_first_line),
    .last          (last)
);

### tb/tb_rect_region_clip_subtract.sv
module tb_rect_region_clip_subtract;

    typedef struct {
        logic [1:0]      status;
        logic            rect_valid;
        rrcs_pkg::rect_t box;
        logic            last;
    } region_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [15:0] first_line;
    logic [15:0] first_column;
    logic [15:0] last_line;
    logic [15:0] last_column;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic        rect_valid;
    logic [15:0] out_first_line;
    logic [15:0] out_first_column;
    logic [15:0] out_last_line;
    logic [15:0] out_last_column;
    logic        last;

    logic            slot_used [rrcs_pkg::STORE_DEPTH];
    rrcs_pkg::rect_t slot_box [rrcs_pkg::STORE_DEPTH];
    region_result_t  pending_results [$];
    int              error_count;
    int              result_count;
    int              item_count;
    int              read_count;
    int              stall_left;
    bit              in_held;
    longint          cycle_count;

    rect_region_clip_subtract dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .op(op),
        .first_line(first_line), .first_column(first_column), .last_line(last_line),
        .last_column(last_column), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .rect_valid(rect_valid), .out_first_line(out_first_line),
        .out_first_column(out_first_column), .out_last_line(out_last_line),
        .out_last_column(out_last_column), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic bit boxes_touch(rrcs_pkg::rect_t r, rrcs_pkg::rect_t o);
        return !(r.fl > o.ll || r.ll < o.fl || r.fc > o.lc || r.lc < o.fc);
    endfunction

    function automatic string result_text(logic [1:0] st, logic rv, rrcs_pkg::rect_t b,
                                          logic lst);
        return $sformatf("%0d %0d %0d %0d %0d %0d %0d", st, rv, b.fl, b.fc, b.ll, b.lc,
            lst);
    endfunction

    function automatic bit store_box(rrcs_pkg::rect_t b);
        for (int i = 0; i < rrcs_pkg::STORE_DEPTH; i++)
        begin
            if (!slot_used[i])
            begin
                slot_box[i] = b;
                slot_used[i] = 1'b1;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit cut_region(rrcs_pkg::rect_t o);
        logic            snap [rrcs_pkg::STORE_DEPTH];
        rrcs_pkg::rect_t r;
        rrcs_pkg::rect_t piece;
        snap = slot_used;
        for (int i = 0; i < rrcs_pkg::STORE_DEPTH; i++)
        begin
            if (!snap[i] || !boxes_touch(slot_box[i], o))
                continue;
            r = slot_box[i];
            if (r.fl < o.fl)
            begin
                piece = '{r.fl, r.fc, o.fl - 16'd1, r.lc};
                if (!store_box(piece))
                begin
                    slot_box[i] = r;
                    return 1'b0;
                end
                r.fl = o.fl;
            end
            if (r.ll > o.ll)
            begin
                piece = '{o.ll + 16'd1, r.fc, r.ll, r.lc};
                if (!store_box(piece))
                begin
                    slot_box[i] = r;
                    return 1'b0;
                end
                r.ll = o.ll;
            end
            if (r.fc < o.fc)
            begin
                piece = '{r.fl, r.fc, r.ll, o.fc - 16'd1};
                if (!store_box(piece))
                begin
                    slot_box[i] = r;
                    return 1'b0;
                end
            end
            if (r.lc > o.lc)
            begin
                piece = '{r.fl, o.lc + 16'd1, r.ll, r.lc};
                if (!store_box(piece))
                begin
                    slot_box[i] = r;
                    return 1'b0;
                end
            end
            slot_used[i] = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_region(logic [1:0] code, rrcs_pkg::rect_t o);
        region_result_t res;
        bit             inverted;
        bit             ok;
        int             top;
        inverted = (o.ll < o.fl) || (o.lc < o.fc);
        res = '{rrcs_pkg::STATUS_EMPTY, 1'b0, '0, 1'b1};
        ok = 1'b1;
        if (code == rrcs_pkg::OP_READ)
        begin
            top = -1;
            for (int i = 0; i < rrcs_pkg::STORE_DEPTH; i++)
                if (slot_used[i])
                    top = i;
            if (top < 0)
                pending_results.push_back(res);
            for (int i = 0; i < rrcs_pkg::STORE_DEPTH; i++)
            begin
                if (slot_used[i])
                begin
                    res = '{rrcs_pkg::STATUS_NONEMPTY, 1'b1, slot_box[i], i == top};
                    pending_results.push_back(res);
                end
            end
            return;
        end
        if (code == rrcs_pkg::OP_ADD)
        begin
            if (!inverted)
                ok = store_box(o);
        end
        else if (code == rrcs_pkg::OP_INTERSECT)
        begin
            for (int i = 0; i < rrcs_pkg::STORE_DEPTH; i++)
            begin
                if (!slot_used[i])
                    continue;
                if (inverted || !boxes_touch(slot_box[i], o))
                begin
                    slot_used[i] = 1'b0;
                    continue;
                end
                if (slot_box[i].fl < o.fl) slot_box[i].fl = o.fl;
                if (slot_box[i].ll > o.ll) slot_box[i].ll = o.ll;
                if (slot_box[i].fc < o.fc) slot_box[i].fc = o.fc;
                if (slot_box[i].lc > o.lc) slot_box[i].lc = o.lc;
            end
        end
        else if (!inverted)
        begin
            ok = cut_region(o);
        end
        if (!ok)
            res.status = rrcs_pkg::STATUS_FULL;
        else
            for (int i = 0; i < rrcs_pkg::STORE_DEPTH; i++)
                if (slot_used[i])
                    res.status = rrcs_pkg::STATUS_NONEMPTY;
        pending_results.push_back(res);
    endfunction

    task automatic release_input();
        if (in_held)
        begin
            in_valid <= 1'b0;
            in_held = 1'b0;
        end
    endtask

    task automatic send_region_op(logic [1:0] code, logic [15:0] fl, logic [15:0] fc,
                                  logic [15:0] ll, logic [15:0] lc);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
            release_input();
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        in_held = 1'b1;
        op <= code;
        first_line <= fl;
        first_column <= fc;
        last_line <= ll;
        last_column <= lc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_region(code, '{fl, fc, ll, lc});
        item_count++;
        if (code == rrcs_pkg::OP_READ)
            read_count++;
    endtask

    task automatic drain_results();
        release_input();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic test_extremes();
        send_region_op(rrcs_pkg::OP_READ, 0, 0, 0, 0);
        send_region_op(rrcs_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_region_op(rrcs_pkg::OP_ADD, 0, 0, 0, 0);
        send_region_op(rrcs_pkg::OP_ADD, 0, 0, 16'hFFFF, 16'hFFFF);
        send_region_op(rrcs_pkg::OP_ADD, 5, 5, 4, 9);
        send_region_op(rrcs_pkg::OP_ADD, 5, 9, 9, 5);
        send_region_op(rrcs_pkg::OP_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_region_op(rrcs_pkg::OP_SUBTRACT, 100, 200, 300, 400);
        send_region_op(rrcs_pkg::OP_READ, 0, 0, 0, 0);
        send_region_op(rrcs_pkg::OP_SUBTRACT, 9, 9, 1, 1);
        send_region_op(rrcs_pkg::OP_INTERSECT, 0, 0, 16'hFFFF, 16'hFFFF);
        send_region_op(rrcs_pkg::OP_INTERSECT, 150, 150, 1000, 1000);
        send_region_op(rrcs_pkg::OP_READ, 0, 0, 0, 0);
        send_region_op(rrcs_pkg::OP_INTERSECT, 10, 10, 5, 20);
        send_region_op(rrcs_pkg::OP_READ, 0, 0, 0, 0);
        send_region_op(rrcs_pkg::OP_SUBTRACT, 0, 0, 16'hFFFF, 16'hFFFF);
        drain_results();
    endtask

    task automatic test_store_full();
        for (int i = 0; i < rrcs_pkg::STORE_DEPTH + 1; i++)
            send_region_op(rrcs_pkg::OP_ADD, 16'(i * 10), 16'(i * 10),
                16'(i * 10 + 8), 16'(i * 10 + 8));
        send_region_op(rrcs_pkg::OP_READ, 0, 0, 0, 0);
        send_region_op(rrcs_pkg::OP_INTERSECT, 0, 0, 150, 150);
        send_region_op(rrcs_pkg::OP_SUBTRACT, 2, 2, 4, 4);
        send_region_op(rrcs_pkg::OP_READ, 0, 0, 0, 0);
        send_region_op(rrcs_pkg::OP_INTERSECT, 1, 1, 0, 0);
        drain_results();
    endtask

    task automatic test_random_ops(int count);
        logic [1:0]  code;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
        int          span;
        for (int n = 0; n < count; n++)
        begin
            code = $urandom_range(0, 9) < 4 ? rrcs_pkg::OP_ADD : 2'($urandom_range(1, 3));
            span = ($urandom_range(0, 7) == 0) ? 65535 : 60;
            a = 16'($urandom_range(0, span));
            b = 16'($urandom_range(0, span));
            c = 16'(a + $urandom_range(0, 20));
            d = 16'(b + $urandom_range(0, 20));
            if ($urandom_range(0, 15) == 0)
            begin
                c = 16'($urandom);
                d = 16'($urandom);
            end
            if ($urandom_range(0, 40) == 0)
                send_region_op(rrcs_pkg::OP_INTERSECT, 0, 0, 16'hFFFF, 16'hFFFF);
            send_region_op(code, a, b, c, d);
            if (n == count / 2)
            begin
                release_input();
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
        end
        drain_results();
    endtask

    always @(posedge clk)
    begin
        region_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d", $time, status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || rect_valid !== want.rect_valid
                    || out_first_line !== want.box.fl || out_first_column !== want.box.fc
                    || out_last_line !== want.box.ll || out_last_column !== want.box.lc
                    || last !== want.last)
                begin
                    $display("%0t: expected %s got %s", $time,
                        result_text(want.status, want.rect_valid, want.box, want.last),
                        result_text(status, rect_valid, '{out_first_line,
                            out_first_column, out_last_line, out_last_column}, last));
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                stall_left = $urandom_range(0, 6);
            else if (stall_left != 0)
                stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 2000000)
        begin
            $display("tb_rect_region_clip_subtract: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_held = 1'b0;
        op = rrcs_pkg::OP_ADD;
        first_line = '0;
        first_column = '0;
        last_line = '0;
        last_column = '0;
        error_count = 0;
        result_count = 0;
        item_count = 0;
        read_count = 0;
        cycle_count = 0;
        for (int i = 0; i < rrcs_pkg::STORE_DEPTH; i++)
            slot_used[i] = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_store_full();
        test_random_ops(270);
        $display("Sent %0d transactions (%0d reads), checked %0d results,", item_count,
            read_count, result_count);
        $display("including full-store failures and inverted operands.");
        if (error_count == 0)
            $display("tb_rect_region_clip_subtract: clean");
        else
            $display("tb_rect_region_clip_subtract: errors");
        $finish;
    end

endmodule

### filelist.f
rtl/rrcs_pkg.sv
rtl/rrcs_ram.sv
rtl/rect_region_clip_subtract.sv
rtl/rrcs_checker.sv
tb/tb_rect_region_clip_subtract.sv
